[hdl/header_synced_frame_receiver_macros.svh]
// Assertion macros for the frame receiver RTL.
// Depends on nothing; included by hsfr_parser, the module that carries assertions.
`ifndef HEADER_SYNCED_FRAME_RECEIVER_MACROS_SVH
`define HEADER_SYNCED_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hsfr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hsfr assertion failed");

`endif

[hdl/hsfr_pkg.sv]
// Package for the header synced frame receiver: header constants,
// parser phase type and the decoded result type. Depends on nothing.
package hsfr_pkg;

    // Header bytes that open every frame.
    localparam logic [7:0] HDR_BYTE_1 = 8'hAA;
    localparam logic [7:0] HDR_BYTE_2 = 8'hBB;
    localparam logic [7:0] HDR_BYTE_3 = 8'hCC;

    // Frame byte counting: the header is three bytes, the frame nine.
    localparam logic [3:0] HDR_LEN  = 4'd3;
    localparam logic [3:0] LAST_POS = 4'd8;

    localparam int TICK_W  = 32;
    localparam int VALUE_W = 16;
    localparam int SHIFT_W = TICK_W + VALUE_W;

    typedef enum logic [1:0] {
        PH_WAIT_H1 = 2'd0,
        PH_WAIT_H2 = 2'd1,
        PH_WAIT_H3 = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    // Result of the parser for the byte in the input register.
    typedef struct packed {
        logic                      done;
        logic [TICK_W-1:0]         tick;
        logic signed [VALUE_W-1:0] value;
    } t_parse_res;

endpackage

[hdl/hsfr_if.sv]
// Handshake interfaces for the received byte channel and the frame channel.
// Depends on hsfr_pkg for the field widths.
interface hsfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hsfr_frame_if;
    logic                               valid;
    logic                               ready;
    logic [hsfr_pkg::TICK_W-1:0]        frame_tick;
    logic signed [hsfr_pkg::VALUE_W-1:0] frame_value;

    modport source (output valid, output frame_tick, output frame_value, input ready);
    modport sink   (input valid, input frame_tick, input frame_value, output ready);
endinterface

[hdl/hsfr_in_reg.sv]
// Input register for received bytes.
// Depends on hsfr_if; the parser drains it whenever the output side has room.
module hsfr_in_reg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsfr_rx_if.sink     i_rx,
    input  logic        i_advance,
    output logic        o_valid,
    output logic [7:0]  o_byte
);
    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;

    // A new request is taken when the register is empty or drains this cycle.
    assign i_rx.ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (i_rx.valid && i_rx.ready) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload register, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

[hdl/hsfr_parser.sv]
// Frame parser: header hunt, payload collection and result decode.
// Depends on hsfr_pkg and the assertion macro header.
`include "header_synced_frame_receiver_macros.svh"
module hsfr_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic [7:0]           i_byte,
    output hsfr_pkg::t_parse_res o_res
);
    import hsfr_pkg::*;

    t_phase               r_phase;
    t_phase               n_phase;
    logic [3:0]           r_pos;
    logic [3:0]           n_pos;
    logic [SHIFT_W-1:0]   r_shift;
    logic [SHIFT_W-1:0]   shifted;

    // Payload shift with the current byte as the newest entry.
    assign shifted = {r_shift[SHIFT_W-9:0], i_byte};

    // Next phase and byte position for the byte in the input register.
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        unique case (r_phase)
            PH_WAIT_H1: begin
                if (i_byte == HDR_BYTE_1) begin
                    n_phase = PH_WAIT_H2;
                end
            end
            PH_WAIT_H2: begin
                n_phase = (i_byte == HDR_BYTE_2) ? PH_WAIT_H3 : PH_WAIT_H1;
            end
            PH_WAIT_H3: begin
                if (i_byte == HDR_BYTE_3) begin
                    n_phase = PH_PAYLOAD;
                    n_pos   = HDR_LEN;
                end else begin
                    n_phase = PH_WAIT_H1;
                end
            end
            PH_PAYLOAD: begin
                if (r_pos == LAST_POS) begin
                    n_phase = PH_WAIT_H1;
                    n_pos   = 4'd0;
                end else begin
                    n_pos = r_pos + 4'd1;
                end
            end
            default: begin
                n_phase = PH_WAIT_H1;
            end
        endcase
    end

    // The ninth frame byte completes a result.
    always_comb begin
        o_res.done  = (r_phase == PH_PAYLOAD) && (r_pos == LAST_POS);
        o_res.tick  = shifted[SHIFT_W-1:VALUE_W];
        o_res.value = signed'(shifted[VALUE_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT_H1;
            r_pos   <= 4'd0;
            r_shift <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            if (r_phase == PH_PAYLOAD) begin
                r_shift <= shifted;
            end
        end
    end

    // Phase and position stay consistent, and a finished frame restarts the hunt.
    `HSFR_ASSERT_NOW(a_pos_idle, i_clk, i_rst_n, r_phase != PH_PAYLOAD, r_pos == 4'd0)
    `HSFR_ASSERT_NOW(a_pos_range, i_clk, i_rst_n, r_phase == PH_PAYLOAD, (r_pos >= HDR_LEN) && (r_pos <= LAST_POS))
    `HSFR_ASSERT_NEXT(a_done_rehunt, i_clk, i_rst_n, i_advance && o_res.done, (r_phase == PH_WAIT_H1) && (r_pos == 4'd0))
    `HSFR_ASSERT_NEXT(a_sync, i_clk, i_rst_n, i_advance && (r_phase == PH_WAIT_H3) && (i_byte == HDR_BYTE_3), (r_phase == PH_PAYLOAD) && (r_pos == HDR_LEN))
endmodule

[hdl/hsfr_out_reg.sv]
// Result register driving the frame channel.
// Depends on hsfr_pkg and hsfr_if.
module hsfr_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  hsfr_pkg::t_parse_res i_res,
    output logic                 o_can_take,
    hsfr_frame_if.source         o_frame
);
    import hsfr_pkg::*;

    logic                      r_valid;
    logic                      n_valid;
    logic [TICK_W-1:0]         r_tick;
    logic signed [VALUE_W-1:0] r_value;
    logic                      load;

    // Room for a new result when empty or when the held one leaves now.
    assign o_can_take = !r_valid || o_frame.ready;
    assign load       = i_advance && i_res.done;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (o_frame.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tick  <= i_res.tick;
            r_value <= i_res.value;
        end
    end

    assign o_frame.valid       = r_valid;
    assign o_frame.frame_tick  = r_tick;
    assign o_frame.frame_value = r_value;
endmodule

[hdl/header_synced_frame_receiver.sv]
// Top level of the header synced frame receiver.
// Depends on hsfr_pkg, hsfr_if, hsfr_in_reg, hsfr_parser and hsfr_out_reg.
//
//   Channel   Dir   Port      Payload
//   bytes     in    i_rx      rx_byte (8 bits)
//   frames    out   o_frame   frame_tick (32 bits), frame_value (16 bits, signed)
//
// One received byte is taken every cycle while the result register has room; the parser updates its phase in one pass.
// After its ninth byte is accepted, a frame result passes through the input register,
// then the result register, from which the frame channel takes it.
// A stalled frame channel holds the result; the input register still takes one byte.
// Reset is synchronous, active low, and restarts the header hunt.
module header_synced_frame_receiver (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hsfr_rx_if.sink      i_rx,
    hsfr_frame_if.source o_frame
);
    import hsfr_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       can_take;
    logic       advance;
    t_parse_res res;

    // The buffered byte moves through the parser when the result side has room.
    assign advance = in_valid && can_take;

    hsfr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    hsfr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (in_byte),
        .o_res     (res)
    );

    hsfr_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_res      (res),
        .o_can_take (can_take),
        .o_frame    (o_frame)
    );
endmodule
